// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bibf_pkg.sv
package bibf_pkg;

  localparam int CODE_W          = 8;
  localparam int START_W         = 16;
  localparam int WORD_W          = 32;
  localparam int LEN_W           = 3;
  localparam int OFFSET_BITS_DEF = 16;

  localparam logic [CODE_W-1:0] OP_TABLESWITCH  = 8'd170;
  localparam logic [CODE_W-1:0] OP_LOOKUPSWITCH = 8'd171;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_SKIP    = 3'd1,
    PH_PAD     = 3'd2,
    PH_DEFAULT = 3'd3,
    PH_FIRST   = 3'd4,
    PH_HIGH    = 3'd5
  } bibf_phase_e;

  typedef struct packed {
    logic               hit;
    logic [START_W-1:0] start_offset;
    logic [CODE_W-1:0]  opcode_value;
    logic               status;
  } bibf_res_t;

  // fixed instruction length, zero for switches, wide and unknown opcodes
  function automatic logic [LEN_W-1:0] insn_len(input logic [CODE_W-1:0] op);
    logic [LEN_W-1:0] len;
    unique case (op) inside
      [8'd0:8'd15]:    len = 3'd1;
      8'd16, 8'd18:    len = 3'd2;
      8'd17, 8'd19, 8'd20: len = 3'd3;
      [8'd21:8'd25]:   len = 3'd2;
      [8'd26:8'd53]:   len = 3'd1;
      [8'd54:8'd58]:   len = 3'd2;
      [8'd59:8'd131]:  len = 3'd1;
      8'd132:          len = 3'd3;
      [8'd133:8'd152]: len = 3'd1;
      [8'd153:8'd168]: len = 3'd3;
      8'd169:          len = 3'd2;
      [8'd172:8'd177]: len = 3'd1;
      [8'd178:8'd184]: len = 3'd3;
      8'd185, 8'd186:  len = 3'd5;
      8'd187:          len = 3'd3;
      8'd188:          len = 3'd2;
      8'd189:          len = 3'd3;
      8'd190, 8'd191:  len = 3'd1;
      8'd192, 8'd193:  len = 3'd3;
      8'd194, 8'd195:  len = 3'd1;
      8'd197:          len = 3'd4;
      8'd198, 8'd199:  len = 3'd3;
      8'd200, 8'd201:  len = 3'd5;
      default:         len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/bibf_if.sv
interface bibf_in_if;
  import bibf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_byte;
  logic              last_byte;
  modport source (output valid, code_byte, last_byte, input ready);
  modport sink   (input valid, code_byte, last_byte, output ready);
endinterface

interface bibf_out_if;
  import bibf_pkg::*;
  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_offset;
  logic [CODE_W-1:0]  opcode_value;
  logic               status;
  modport source (output valid, start_offset, opcode_value, status, input ready);
  modport sink   (input valid, start_offset, opcode_value, status, output ready);
endinterface

// File: rtl/bytecode_instruction_boundary_finder.sv
// path: an accepted byte is held in the input register stage, then its result in the result register stage
// throughput: one byte per cycle, sustained while the output side keeps taking
// results; the combinational parse step between input and result registers sets it
// reset: asynchronous active low; clears the offset, parse phase, halt flag and
// both valid flags, so the next byte is offset 0 and is read as an opcode
module bytecode_instruction_boundary_finder #(
  parameter int OFFSET_BITS = bibf_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bibf_in_if.sink     code_i,
  bibf_out_if.source  insn_o
);
  import bibf_pkg::*;
  `include "assert_macros.svh"

  // input register stage
  logic              in_vld_q;
  logic [CODE_W-1:0] byte_q;
  logic              last_q;

  // result register stage
  logic               out_vld_q;
  logic [START_W-1:0] start_q;
  logic [CODE_W-1:0]  opcode_q;
  logic               status_q;

  logic      advance;
  bibf_res_t res;

  // the held byte moves through the parse step when the result slot is free
  // or being emptied in this cycle; bytes without a result advance the same way
  assign advance     = in_vld_q && (!out_vld_q || insn_o.ready);
  assign code_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (code_i.ready) begin
      in_vld_q <= code_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_i.valid && code_i.ready) begin
      byte_q <= code_i.code_byte;
      last_q <= code_i.last_byte;
    end
  end

  // parse state machine: offset, operand skip count, switch word assembly
  bibf_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .code_byte_i (byte_q),
    .last_byte_i (last_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.hit;
    end else if (insn_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.hit) begin
      start_q  <= res.start_offset;
      opcode_q <= res.opcode_value;
      status_q <= res.status;
    end
  end

  assign insn_o.valid        = out_vld_q;
  assign insn_o.start_offset = start_q;
  assign insn_o.opcode_value = opcode_q;
  assign insn_o.status       = status_q;

  // input stalls only when both stages are full and the output is blocked
  `ASSERT_ALWAYS(a_stall_cause, clk_i, rst_ni, !code_i.ready |-> (in_vld_q && out_vld_q && !insn_o.ready), "input stalled without a full pipeline")
  // a result appears only from a byte going through the parse step
  `ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !advance && !out_vld_q, !out_vld_q, "result without a parsed byte")
  // error status only for opcodes with no fixed length that are not switches
  `ASSERT_ALWAYS(a_err_opcode, clk_i, rst_ni, (in_vld_q && res.hit && res.status) |-> (insn_len(res.opcode_value) == 3'd0 && res.opcode_value != OP_TABLESWITCH && res.opcode_value != OP_LOOKUPSWITCH), "error on a known opcode")

endmodule

// File: rtl/bibf_parser.sv
module bibf_parser #(
  parameter int OFFSET_BITS = bibf_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [bibf_pkg::CODE_W-1:0] code_byte_i,
  input  logic                      last_byte_i,
  output bibf_pkg::bibf_res_t       res_o
);
  import bibf_pkg::*;

  logic [OFFSET_BITS-1:0] off_q, off_d;
  bibf_phase_e            phase_q, phase_d;
  logic [WORD_W-1:0]      skip_q, skip_d;
  logic [WORD_W-1:0]      word_q, word_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [WORD_W-1:0]      low_q, low_d;
  logic                   table_q, table_d;
  logic                   halted_q, halted_d;

  always_comb begin
    logic [WORD_W-1:0] off_ext;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] cnt_skip;
    logic [LEN_W-1:0]  len;
    logic              do_skip;

    off_d    = off_q;
    phase_d  = phase_q;
    skip_d   = skip_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    low_d    = low_q;
    table_d  = table_q;
    halted_d = halted_q;
    res_o    = '0;
    off_ext  = WORD_W'(off_q);
    len      = insn_len(code_byte_i);
    span     = '0;
    cnt_skip = '0;
    do_skip  = 1'b0;

    if (!halted_q) begin
      unique case (phase_q)
        PH_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) phase_d = PH_OPCODE;
        end
        PH_PAD: begin
          // next offset is 4-aligned
          if (off_q[1:0] == 2'b11) phase_d = PH_DEFAULT;
        end
        PH_DEFAULT, PH_FIRST, PH_HIGH: begin
          word_d = {word_q[WORD_W-9:0], code_byte_i};
          if (cnt_q != 2'd3) begin
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d = 2'd0;
            if (phase_q == PH_DEFAULT) begin
              phase_d = PH_FIRST;
            end else if (phase_q == PH_FIRST) begin
              if (table_q) begin
                low_d   = word_d;
                phase_d = PH_HIGH;
              end else begin
                // npairs * 8
                cnt_skip = {word_d[WORD_W-4:0], 3'b000};
                do_skip  = 1'b1;
              end
            end else begin
              // (high - low + 1) * 4
              span     = word_d - low_q + 32'd1;
              cnt_skip = {span[WORD_W-3:0], 2'b00};
              do_skip  = 1'b1;
            end
          end
        end
        default: begin
          res_o.hit          = 1'b1;
          res_o.start_offset = off_ext[START_W-1:0];
          res_o.opcode_value = code_byte_i;
          if (len != '0) begin
            cnt_skip = WORD_W'(len - 3'd1);
            do_skip  = 1'b1;
          end else if (code_byte_i == OP_TABLESWITCH ||
                       code_byte_i == OP_LOOKUPSWITCH) begin
            table_d = (code_byte_i == OP_TABLESWITCH);
            word_d  = '0;
            cnt_d   = 2'd0;
            phase_d = (off_q[1:0] != 2'b11) ? PH_PAD : PH_DEFAULT;
          end else begin
            res_o.status = 1'b1;
            halted_d     = 1'b1;
          end
        end
      endcase
    end

    if (do_skip) begin
      skip_d  = cnt_skip;
      phase_d = (cnt_skip != '0) ? PH_SKIP : PH_OPCODE;
    end

    // end of method: back to the reset state
    if (last_byte_i) begin
      off_d    = '0;
      phase_d  = PH_OPCODE;
      skip_d   = '0;
      word_d   = '0;
      cnt_d    = 2'd0;
      low_d    = '0;
      table_d  = 1'b0;
      halted_d = 1'b0;
    end else begin
      off_d = off_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      phase_q  <= PH_OPCODE;
      skip_q   <= '0;
      word_q   <= '0;
      cnt_q    <= 2'd0;
      low_q    <= '0;
      table_q  <= 1'b0;
      halted_q <= 1'b0;
    end else if (en_i) begin
      off_q    <= off_d;
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      word_q   <= word_d;
      cnt_q    <= cnt_d;
      low_q    <= low_d;
      table_q  <= table_d;
      halted_q <= halted_d;
    end
  end

endmodule

// File: tb/bytecode_instruction_boundary_finder_tb.sv
`timescale 1ns / 100ps

module bytecode_instruction_boundary_finder_tb;
  import bibf_pkg::*;

  // clock and run control
  localparam int     CLK_PERIOD   = 8;
  localparam int     RESET_CYCLES = 10;
  localparam longint TIMEOUT_NS   = 64'd24_000_000;
  localparam int     DRAIN_LIMIT  = 5000;
  localparam int     SETTLE       = 6;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     RANDOM_BYTES = 700;

  // opcodes the stimulus names
  localparam logic [CODE_W-1:0] OP_NOP           = 8'd0;
  localparam logic [CODE_W-1:0] OP_BIPUSH        = 8'd16;
  localparam logic [CODE_W-1:0] OP_SIPUSH        = 8'd17;
  localparam logic [CODE_W-1:0] OP_WIDE          = 8'd196;
  localparam logic [CODE_W-1:0] OP_FIRST_UNKNOWN = 8'd202;
  localparam logic [CODE_W-1:0] OP_MAX_CODE      = 8'd255;

  // result status codes
  localparam logic ST_START = 1'b0;
  localparam logic ST_HALT  = 1'b1;

  typedef struct packed {
    logic [START_W-1:0] start_offset;
    logic [CODE_W-1:0]  opcode_value;
    logic               status;
  } boundary_t;

  logic clk_i;
  logic rst_ni;

  bibf_in_if  code_bus ();
  bibf_out_if insn_bus ();

  bytecode_instruction_boundary_finder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .code_i (code_bus),
    .insn_o (insn_bus)
  );

  // shadow copy of the parser state
  logic [OFFSET_BITS_DEF-1:0] shadow_offset;
  bibf_phase_e                shadow_phase;
  logic [WORD_W-1:0]          shadow_skip;
  logic [WORD_W-1:0]          shadow_word;
  logic [1:0]                 shadow_word_cnt;
  logic [WORD_W-1:0]          shadow_low;
  logic                       shadow_table_form;
  logic                       shadow_halted;

  // boundaries predicted but not yet seen on the output
  boundary_t expected_boundaries[$];
  boundary_t head;

  // bytes of the method being sent, offset 0 first
  logic [CODE_W-1:0] method_bytes[$];

  // idling controls, set per test
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold;
  int rx_stall;

  // request accepted at the last rising edge
  bit in_taken;

  int err_count;
  int bytes_sent;
  int methods_sent;
  int results_checked;
  int halt_results;

  // clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // fixed instruction length, zero where the length is not fixed
  function automatic int unsigned fixed_length(input logic [CODE_W-1:0] op);
    if (op >= OP_FIRST_UNKNOWN || op == OP_WIDE ||
        op == OP_TABLESWITCH || op == OP_LOOKUPSWITCH)
      return 0;
    case (op)
      16, 18, 21, 22, 23, 24, 25, 54, 55, 56, 57, 58, 169, 188: return 2;
      17, 19, 20, 132, 153, 154, 155, 156, 157, 158, 159, 160, 161, 162,
      163, 164, 165, 166, 167, 168, 178, 179, 180, 181, 182, 183, 184,
      187, 189, 192, 193, 198, 199:                             return 3;
      197:                                                      return 4;
      185, 186, 200, 201:                                       return 5;
      default:                                                  return 1;
    endcase
  endfunction

  function automatic void clear_shadow();
    shadow_offset     = '0;
    shadow_phase      = PH_OPCODE;
    shadow_skip       = '0;
    shadow_word       = '0;
    shadow_word_cnt   = '0;
    shadow_low        = '0;
    shadow_table_form = 1'b0;
    shadow_halted     = 1'b0;
  endfunction

  // enter operand skipping, straight back to opcode on a zero count
  function automatic void start_skip(input logic [WORD_W-1:0] count);
    shadow_skip  = count;
    shadow_phase = (count != 0) ? PH_SKIP : PH_OPCODE;
  endfunction

  // advance the shadow parser by one byte, queue any boundary it finds
  function automatic void predict_boundary(input logic [CODE_W-1:0] b, input logic last);
    logic [OFFSET_BITS_DEF-1:0] cur;
    logic [OFFSET_BITS_DEF-1:0] nxt;
    boundary_t                  rec;
    int unsigned                len;
    cur = shadow_offset;
    nxt = shadow_offset + 1'b1;
    if (!shadow_halted) begin
      case (shadow_phase)
        PH_SKIP: begin
          shadow_skip = shadow_skip - 1;
          if (shadow_skip == 0) shadow_phase = PH_OPCODE;
        end
        PH_PAD: begin
          // padding ends once the next offset is word aligned
          if (nxt[1:0] == 2'b00) shadow_phase = PH_DEFAULT;
        end
        PH_DEFAULT, PH_FIRST, PH_HIGH: begin
          // big-endian word collection
          shadow_word = {shadow_word[WORD_W-9:0], b};
          if (shadow_word_cnt != 2'd3) begin
            shadow_word_cnt = shadow_word_cnt + 1'b1;
          end else begin
            shadow_word_cnt = '0;
            if (shadow_phase == PH_DEFAULT) begin
              shadow_phase = PH_FIRST;
            end else if (shadow_phase == PH_FIRST) begin
              if (shadow_table_form) begin
                shadow_low   = shadow_word;
                shadow_phase = PH_HIGH;
              end else begin
                start_skip(shadow_word << 3);
              end
            end else begin
              start_skip((shadow_word - shadow_low + 1) << 2);
            end
          end
        end
        default: begin
          rec.start_offset = cur[START_W-1:0];
          rec.opcode_value = b;
          rec.status       = ST_START;
          len = fixed_length(b);
          if (len != 0) begin
            start_skip(len - 1);
          end else if (b == OP_TABLESWITCH || b == OP_LOOKUPSWITCH) begin
            shadow_table_form = (b == OP_TABLESWITCH);
            shadow_word       = '0;
            shadow_word_cnt   = '0;
            shadow_phase      = (nxt[1:0] != 2'b00) ? PH_PAD : PH_DEFAULT;
          end else begin
            // wide or unknown opcode halts parsing until the method ends
            rec.status    = ST_HALT;
            shadow_halted = 1'b1;
          end
          expected_boundaries.push_back(rec);
        end
      endcase
    end
    if (last) clear_shadow();
    else      shadow_offset = nxt;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(6, 24);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [CODE_W-1:0] random_byte();
    return CODE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CODE_W-1:0] random_fixed_opcode();
    logic [CODE_W-1:0] op;
    do op = random_byte(); while (fixed_length(op) == 0);
    return op;
  endfunction

  function automatic void push_word(input logic [WORD_W-1:0] w);
    method_bytes.push_back(w[31:24]);
    method_bytes.push_back(w[23:16]);
    method_bytes.push_back(w[15:8]);
    method_bytes.push_back(w[7:0]);
  endfunction

  function automatic void push_fixed_insn(input logic [CODE_W-1:0] op);
    method_bytes.push_back(op);
    repeat (fixed_length(op) - 1) method_bytes.push_back(random_byte());
  endfunction

  // switch with padding and header words; returns 1 when the skip is too long
  // to send, in which case the method is cut short inside the jump table
  function automatic bit push_switch(input logic [CODE_W-1:0] op,
                                     input logic [WORD_W-1:0] first,
                                     input logic [WORD_W-1:0] high);
    logic [WORD_W-1:0] skip;
    method_bytes.push_back(op);
    while (method_bytes.size() % 4 != 0) method_bytes.push_back(random_byte());
    push_word($urandom);
    push_word(first);
    if (op == OP_TABLESWITCH) begin
      push_word(high);
      skip = (high - first + 1) << 2;
    end else begin
      skip = first << 3;
    end
    if (skip <= 64) begin
      repeat (skip) method_bytes.push_back(random_byte());
      return 1'b0;
    end
    repeat ($urandom_range(0, 6)) method_bytes.push_back(random_byte());
    return 1'b1;
  endfunction

  // one well-formed instruction with random content; 1 means the method ends here
  function automatic bit push_random_insn();
    int                pick;
    int                sel;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] npairs;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 5);
    lo   = $urandom;
    if (pick < 72) begin
      push_fixed_insn(random_fixed_opcode());
      return 1'b0;
    end
    if (pick < 82) begin
      // small tables, one whose entry count wraps to a short skip, one huge
      if (sel < 4)       hi = lo + sel - 1;
      else if (sel == 4) hi = lo + 32'h4000_0000;
      else               hi = $urandom;
      return push_switch(OP_TABLESWITCH, lo, hi);
    end
    if (pick < 92) begin
      if (sel < 4)       npairs = sel;
      else if (sel == 4) npairs = 32'h2000_0001;
      else               npairs = $urandom;
      return push_switch(OP_LOOKUPSWITCH, npairs, '0);
    end
    if ($urandom_range(0, 3) == 0) method_bytes.push_back(OP_WIDE);
    else method_bytes.push_back(
        CODE_W'($urandom_range(int'(OP_FIRST_UNKNOWN), int'(OP_MAX_CODE))));
    repeat ($urandom_range(0, 4)) method_bytes.push_back(random_byte());
    return 1'b1;
  endfunction

  function automatic void build_method(input int n_insns);
    method_bytes.delete();
    for (int i = 0; i < n_insns; i++)
      if (push_random_insn()) break;
  endfunction

  // offer one byte at the falling edge, hold it until the request is taken
  task automatic send_byte(input logic [CODE_W-1:0] b, input logic last);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      code_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    code_bus.valid     = 1'b1;
    code_bus.code_byte = b;
    code_bus.last_byte = last;
    do @(negedge clk_i); while (!in_taken);
    bytes_sent++;
  endtask

  task automatic send_method();
    int n;
    n = method_bytes.size();
    for (int i = 0; i < n; i++) send_byte(method_bytes[i], i == n - 1);
    methods_sent++;
  endtask

  // sender pauses until every predicted boundary has come out or the drain limit runs out
  task automatic wait_drained();
    int n;
    n = 0;
    code_bus.valid = 1'b0;
    while (expected_boundaries.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk_i);
      n++;
    end
    if (expected_boundaries.size() != 0) begin
      $error("%0d predicted boundaries never arrived", expected_boundaries.size());
      err_count++;
    end
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // input side: every accepted request feeds the shadow parser
  always @(posedge clk_i) begin
    in_taken = rst_ni && code_bus.valid && code_bus.ready;
    if (in_taken) predict_boundary(code_bus.code_byte, code_bus.last_byte);
  end

  // output side: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && insn_bus.valid && insn_bus.ready) begin
      if (expected_boundaries.size() == 0) begin
        $error("unexpected result: start_offset %0d opcode_value %0d status %0d",
               insn_bus.start_offset, insn_bus.opcode_value, insn_bus.status);
        err_count++;
      end else begin
        head = expected_boundaries.pop_front();
        if (insn_bus.start_offset !== head.start_offset) begin
          $error("start_offset: expected %0d, actual %0d",
                 head.start_offset, insn_bus.start_offset);
          err_count++;
        end
        if (insn_bus.opcode_value !== head.opcode_value) begin
          $error("opcode_value: expected %0d, actual %0d",
                 head.opcode_value, insn_bus.opcode_value);
          err_count++;
        end
        if (insn_bus.status !== head.status) begin
          $error("status: expected %0d, actual %0d", head.status, insn_bus.status);
          err_count++;
        end
        results_checked++;
        if (head.status == ST_HALT) halt_results++;
      end
    end
  end

  // receiver: long hold-off first, then random stalls when enabled
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      insn_bus.ready = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      insn_bus.ready = 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      rx_stall       = pick_gap();
      insn_bus.ready = 1'b0;
    end else begin
      insn_bus.ready = 1'b1;
    end
  end

  // truncation, halting, errors on the last byte, and an empty lookupswitch
  // entered through padding
  task automatic test_directed_cases();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // single opcode that is also the last byte
    method_bytes = '{OP_NOP};
    send_method();
    // unknown opcode on the last byte
    method_bytes = '{OP_MAX_CODE};
    send_method();
    // wide halts parsing, the trailing bytes give nothing
    method_bytes = '{OP_BIPUSH, 8'hFF, OP_WIDE, 8'h00, 8'hAA};
    send_method();
    // method ends inside the operands of sipush
    method_bytes = '{OP_SIPUSH, 8'h00};
    send_method();
    // lookupswitch at offset 1, two padding bytes, zero pairs, then an error
    method_bytes = '{OP_NOP, OP_LOOKUPSWITCH, 8'h00, 8'h00,
                     8'h12, 8'h34, 8'h56, 8'h78,
                     8'h00, 8'h00, 8'h00, 8'h00, OP_FIRST_UNKNOWN};
    send_method();
    wait_drained();
  endtask

  // every opcode value in a method of its own
  task automatic test_every_opcode();
    logic [CODE_W-1:0] op;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int op_i = 0; op_i < 256; op_i++) begin
      op = CODE_W'(op_i);
      method_bytes.delete();
      if (fixed_length(op) != 0)        push_fixed_insn(op);
      else if (op == OP_TABLESWITCH)    void'(push_switch(op, '0, '0));
      else if (op == OP_LOOKUPSWITCH)   void'(push_switch(op, 32'd1, '0));
      else                              method_bytes.push_back(op);
      send_method();
    end
    wait_drained();
  endtask

  // mostly well-formed methods, some noise, some cut short at a random byte
  task automatic test_random_methods();
    int start_count;
    int keep;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      // idling on or off per method, so some stretches run flat out
      tx_idle_on = ($urandom_range(0, 4) != 0);
      rx_idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        method_bytes.delete();
        repeat ($urandom_range(1, 24)) method_bytes.push_back(random_byte());
      end else begin
        build_method($urandom_range(1, 12));
      end
      if (method_bytes.size() > 1 && $urandom_range(0, 7) == 0) begin
        keep = $urandom_range(1, method_bytes.size() - 1);
        while (method_bytes.size() > keep) void'(method_bytes.pop_back());
      end
      send_method();
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold    = HOLD_CYCLES;
    method_bytes.delete();
    repeat (60) push_fixed_insn(random_fixed_opcode());
    send_method();
    wait_drained();
  endtask

  initial begin
    // all block inputs known from time zero
    rst_ni             = 1'b0;
    code_bus.valid     = 1'b0;
    code_bus.code_byte = '0;
    code_bus.last_byte = 1'b0;
    insn_bus.ready     = 1'b0;
    tx_idle_on         = 1'b0;
    rx_idle_on         = 1'b0;
    rx_hold            = 0;
    rx_stall           = 0;
    in_taken           = 1'b0;
    err_count          = 0;
    bytes_sent         = 0;
    methods_sent       = 0;
    results_checked    = 0;
    halt_results       = 0;
    clear_shadow();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_every_opcode();
    test_output_backpressure();
    test_random_methods();

    $display("covered %0d methods, %0d bytes, every opcode, cut-short methods and hold-off",
             methods_sent, bytes_sent);
    $display("checked %0d boundaries, %0d of them halting errors",
             results_checked, halt_results);
    if (err_count == 0) $display("ALL CHECKS PASSED");
    else                $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: bytecode_instruction_boundary_finder.f
+incdir+rtl
rtl/bibf_pkg.sv
rtl/bibf_if.sv
rtl/bibf_parser.sv
rtl/bytecode_instruction_boundary_finder.sv
tb/bytecode_instruction_boundary_finder_tb.sv
